FILE: hw/rtl/pee_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Holds the character codes, status codes, operation classes and the queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

  // ASCII codes that the front end recognizes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Result status codes; the first error of an expression is kept.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_BADCH = 3'd4;

  // Number of decoded characters buffered between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operation class that the front end assigns to each character.
  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_t;

  // One decoded character as it travels through the queue.
  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } q_entry_t;

  // Handshake from the queue toward the back end.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pee_front.sv
// Front end of the postfix evaluator: accepts characters and classifies them.
// Produces one queue entry per transaction; depends on pee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pee_front (
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [7:0]        char_code,
  input  wire logic              end_of_expr,
  input  wire logic              queue_full,
  output logic                   push,
  output pee_pkg::q_entry_t      push_entry
);
  import pee_pkg::*;

  // The input side stalls only while the queue has no free slot.
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  // Classify the character into an operation class and a digit value.
  always_comb begin
    push_entry.digit = 4'(char_code - CH_ZERO);
    push_entry.last  = end_of_expr;
    if (char_code inside {[CH_ZERO:CH_NINE]}) begin
      push_entry.op = OP_DIGIT;
    end else begin
      case (char_code)
        CH_PLUS:  push_entry.op = OP_ADD;
        CH_MINUS: push_entry.op = OP_SUB;
        CH_STAR:  push_entry.op = OP_MUL;
        CH_SLASH: push_entry.op = OP_DIV;
        default:  push_entry.op = OP_BAD;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pee_queue.sv
// Small FIFO of decoded characters between front and back end.
// Depth is fixed by QUEUE_DEPTH; depends on pee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pee_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pee_pkg::q_entry_t push_entry,
  output logic                   full,
  output pee_pkg::q_head_t       head,
  input  wire logic              pop
);
  import pee_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [FILL_W-1:0]     fill;

  assign full       = (fill == FILL_W'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.entry = slots[rd_ptr];

  // Entry storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QUEUE_AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QUEUE_AW'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   fill <= FILL_W'(fill + 1'b1);
        2'b01:   fill <= FILL_W'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pee_back.sv
// Back end of the postfix evaluator: operand stack, arithmetic and result register.
// Top of stack lives in a register, the rest in a memory; depends on pee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pee_back #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pee_pkg::q_head_t head,
  output logic                  pop,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [31:0]           value,
  output logic [2:0]            status
);
  import pee_pkg::*;

  localparam int DW        = DATA_WIDTH;
  localparam int CW        = $clog2(STACK_DEPTH + 1);
  localparam int AW        = $clog2(STACK_DEPTH);
  localparam int IW        = $clog2(DATA_WIDTH);
  localparam int MUL_CHUNK = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int MUL_STEPS = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIX  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [2:0]       err, err_next;
  logic [DW-1:0]    tos, tos_next;
  op_t              cur_op, cur_op_next;
  logic             cur_last, cur_last_next;
  logic [DW-1:0]    wa, wa_next;
  logic [DW-1:0]    wb, wb_next;
  logic [DW-1:0]    acc, acc_next;
  logic [IW-1:0]    iter, iter_next;
  logic             neg, neg_next;
  logic             res_valid_next;
  logic [31:0]      value_next;
  logic [2:0]       status_next;

  // Stack memory below the top entry.
  logic [DW-1:0]    mem [STACK_DEPTH];
  logic [DW-1:0]    rd_data;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;

  // Arithmetic helpers.
  logic [DW+MUL_CHUNK-1:0] prod;
  logic [DW-1:0]           acc_sum;
  logic [DW+1:0]           trial;
  logic                    can_emit;
  state_t                  done_state;

  assign mem_waddr = AW'(count - 1'b1);
  assign mem_raddr = AW'(count - 2'd2);
  assign prod      = wa * wb[MUL_CHUNK-1:0];
  assign acc_sum   = acc + prod[DW-1:0];
  assign trial     = {1'b0, acc, wa[DW-1]} - {2'b00, wb};
  assign can_emit  = !result_valid || !result_stall;
  assign done_state = cur_last ? S_EMIT : S_IDLE;

  // Keep the first error of an expression.
  function automatic logic [2:0] flag(input logic [2:0] cur, input logic [2:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  // Stack memory: the old top is spilled on a push, the next entry is read for an operator.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= tos;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_next     = state;
    count_next     = count;
    err_next       = err;
    tos_next       = tos;
    cur_op_next    = cur_op;
    cur_last_next  = cur_last;
    wa_next        = wa;
    wb_next        = wb;
    acc_next       = acc;
    iter_next      = iter;
    neg_next       = neg;
    res_valid_next = result_valid && result_stall;
    value_next     = value;
    status_next    = status;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    case (state)
      // Take one decoded character; digits, bad characters and operators without two operands finish here.
      S_IDLE: begin
        if (head.valid) begin
          pop           = 1'b1;
          cur_op_next   = head.entry.op;
          cur_last_next = head.entry.last;
          state_next    = head.entry.last ? S_EMIT : S_IDLE;
          case (head.entry.op)
            OP_DIGIT: begin
              if (count == CW'(STACK_DEPTH)) begin
                err_next = flag(err, ST_OVER);
              end else begin
                mem_we     = (count != '0);
                tos_next   = DW'(head.entry.digit);
                count_next = CW'(count + 1'b1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (count < CW'(2)) begin
                err_next = flag(err, ST_UNDER);
              end else begin
                mem_re     = 1'b1;
                state_next = S_READ;
              end
            end
            default: begin
              err_next = flag(err, ST_BADCH);
            end
          endcase
        end
      end

      // Left operand is in rd_data, right operand is the top register.
      S_READ: begin
        count_next = CW'(count - 1'b1);
        state_next = done_state;
        case (cur_op)
          OP_ADD: tos_next = rd_data + tos;
          OP_SUB: tos_next = rd_data - tos;
          OP_MUL: begin
            wa_next    = rd_data;
            wb_next    = tos;
            acc_next   = '0;
            iter_next  = '0;
            state_next = S_MUL;
          end
          OP_DIV: begin
            if (tos == '0) begin
              err_next = flag(err, ST_DIVZ);
              tos_next = '0;
            end else begin
              wa_next    = rd_data[DW-1] ? -rd_data : rd_data;
              wb_next    = tos[DW-1] ? -tos : tos;
              neg_next   = rd_data[DW-1] ^ tos[DW-1];
              acc_next   = '0;
              iter_next  = '0;
              state_next = S_DIV;
            end
          end
          default: tos_next = tos;
        endcase
      end

      // Multiply one chunk of the right operand per cycle.
      S_MUL: begin
        if (iter == IW'(MUL_STEPS - 1)) begin
          tos_next   = acc_sum;
          state_next = done_state;
        end else begin
          acc_next  = acc_sum;
          wa_next   = wa << MUL_CHUNK;
          wb_next   = wb >> MUL_CHUNK;
          iter_next = IW'(iter + 1'b1);
        end
      end

      // Restoring division on magnitudes, one quotient bit per cycle.
      S_DIV: begin
        if (!trial[DW+1]) begin
          acc_next = trial[DW-1:0];
          wa_next  = {wa[DW-2:0], 1'b1};
        end else begin
          acc_next = {acc[DW-2:0], wa[DW-1]};
          wa_next  = {wa[DW-2:0], 1'b0};
        end
        iter_next = IW'(iter + 1'b1);
        if (iter == IW'(DW - 1)) begin
          state_next = S_FIX;
        end
      end

      // Apply the quotient sign.
      S_FIX: begin
        tos_next   = neg ? -wa : wa;
        state_next = done_state;
      end

      // Hand out the result, then clear stack and status.
      S_EMIT: begin
        if (can_emit) begin
          res_valid_next = 1'b1;
          value_next     = (count == '0) ? 32'd0 : 32'($signed(tos));
          status_next    = (count == '0) ? flag(err, ST_UNDER) : err;
          count_next     = '0;
          err_next       = ST_OK;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      err          <= err_next;
      result_valid <= res_valid_next;
    end
  end

  // Datapath and result payload registers.
  always_ff @(posedge clk) begin
    tos      <= tos_next;
    cur_op   <= cur_op_next;
    cur_last <= cur_last_next;
    wa       <= wa_next;
    wb       <= wb_next;
    acc      <= acc_next;
    iter     <= iter_next;
    neg      <= neg_next;
    value    <= value_next;
    status   <= status_next;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator.
// Connects pee_front, pee_queue and pee_back; depends on pee_pkg.
//
//   Channel   Ports                                   Transaction
//   item      item_valid, item_stall, char_code,      one character
//             end_of_expr
//   result    result_valid, result_stall, value,      value and status of one
//             status                                  expression
//
// In the back end, a digit, a bad character or an operator without two
// operands is done on intake; + and - also read the next stack entry; *
// then sums partial products over chunks of up to 16 bits of the right
// operand; / runs the one-bit-per-cycle divider and applies the sign if the
// divisor is nonzero. The last character also loads the result register.
// A four-entry queue lets the input keep accepting while the back end works.
// Reset (rst, synchronous) empties the queue, the stack and the status.
// A stalled result holds the back end only when the next result is due.
`timescale 1ns / 1ps
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_expr,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      value,
  output logic [2:0]       status
);
  import pee_pkg::*;

  logic     push;
  logic     queue_full;
  logic     pop;
  q_entry_t push_entry;
  q_head_t  head;

  // Character intake and classification.
  pee_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .char_code  (char_code),
    .end_of_expr(end_of_expr),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  pee_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .head      (head),
    .pop       (pop)
  );

  // Stack machine and result register.
  pee_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .value       (value),
    .status      (status)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pee_checker.sv
// Port-level checks for the postfix expression evaluator, bound to the top level.
// Depends on pee_pkg and postfix_expression_evaluator.
`timescale 1ns / 1ps
`default_nettype none

module pee_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [31:0] value,
  input wire logic [2:0]  status
);
  import pee_pkg::*;

  // A stalled result stays offered with the same payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(value) && $stable(status))
    else $error("stalled result changed or was dropped");

  // Only defined status codes are ever reported.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= ST_BADCH)
    else $error("undefined status code");

  // Reset leaves no result pending.
  a_reset_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // Reset empties the queue, so the input side is open right after it.
  a_reset_open: assert property (@(posedge clk)
    rst |=> !item_stall)
    else $error("input stalled after reset");

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .value       (value),
  .status      (status)
);

`default_nettype wire
